// File: sv/button_long_press_repeat_core_macros.svh
// Assertion helpers used by the RTL of the button block.
`ifndef BUTTON_LONG_PRESS_REPEAT_CORE_MACROS_SVH
`define BUTTON_LONG_PRESS_REPEAT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BLPR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("button block assertion failed");

// Next-cycle implication, disabled while reset is high.
`define BLPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("button block assertion failed");

`endif

// File: sv/blpr_pkg.sv
`default_nettype none

package blpr_pkg;

   localparam int CFG_DEBOUNCE_W = 8;
   localparam int CFG_TICKS_W    = 16;
   localparam int STABLE_W       = 8;

   localparam logic [CFG_DEBOUNCE_W-1:0] DEBOUNCE_RESET   = 8'd30;
   localparam logic [CFG_TICKS_W-1:0]    LONG_PRESS_RESET = 16'd1000;
   localparam logic [CFG_TICKS_W-1:0]    REPEAT_RESET     = 16'd300;

   localparam int CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      REG_DEBOUNCE   = 2'd0,
      REG_LONG_PRESS = 2'd1,
      REG_REPEAT     = 2'd2,
      REG_UNUSED     = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_PRESS    = 3'd1,
      EV_LONG     = 3'd2,
      EV_REPEAT   = 3'd3,
      EV_CLICK    = 3'd4,
      EV_HOLD_END = 3'd5
   } event_type;

   typedef struct packed {
      logic [CFG_DEBOUNCE_W-1:0] debounce_ticks;
      logic [CFG_TICKS_W-1:0]    long_press_ticks;
      logic [CFG_TICKS_W-1:0]    repeat_ticks;
   } cfg_type;

   typedef struct packed {
      logic      pressed;
      event_type event_code;
   } rsp_word_type;

endpackage

`default_nettype wire

// File: sv/blpr_core.sv
`default_nettype none

module blpr_core #(
   parameter int TIMER_WIDTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic                  raw_level,
   input  wire blpr_pkg::cfg_type     cfg,
   output blpr_pkg::rsp_word_type     word
);

   localparam int CMP_W = (TIMER_WIDTH > blpr_pkg::CFG_TICKS_W) ? TIMER_WIDTH
                                                               : blpr_pkg::CFG_TICKS_W;

   logic                           last_raw_ff, last_raw_in;
   logic [blpr_pkg::STABLE_W-1:0]  stable_count_ff, stable_count_in;
   logic                           debounced_ff, debounced_in;
   logic                           long_active_ff, long_active_in;
   logic [TIMER_WIDTH-1:0]         held_count_ff, held_count_in;
   logic [TIMER_WIDTH-1:0]         since_repeat_ff, since_repeat_in;

   logic                           changed;
   logic [blpr_pkg::STABLE_W-1:0]  stable_inc;
   logic                           flip;
   logic                           fell;
   logic                           rose;
   logic [TIMER_WIDTH-1:0]         held_mid;
   logic [TIMER_WIDTH-1:0]         since_mid;
   logic                           long_mid;
   logic                           long_fire;
   logic                           repeat_fire;
   blpr_pkg::event_type            event_code;

   always_comb begin
      changed    = (raw_level != last_raw_ff);
      stable_inc = (stable_count_ff == '1) ? stable_count_ff : stable_count_ff + 1'b1;
      flip       = !changed && (stable_inc >= cfg.debounce_ticks) &&
                   (raw_level != debounced_ff);
      fell       = flip && !raw_level;
      rose       = flip && raw_level;

      last_raw_in     = raw_level;
      stable_count_in = changed ? '0 : stable_inc;
      debounced_in    = flip ? raw_level : debounced_ff;

      held_mid  = held_count_ff;
      since_mid = since_repeat_ff;
      long_mid  = long_active_ff;
      if (fell) begin
         held_mid = '0;
         long_mid = 1'b0;
      end else if (!debounced_in) begin
         held_mid = (held_count_ff == '1) ? held_count_ff : held_count_ff + 1'b1;
         if (long_active_ff) begin
            since_mid = (since_repeat_ff == '1) ? since_repeat_ff : since_repeat_ff + 1'b1;
         end
      end

      long_fire   = !debounced_in && !fell && !long_mid &&
                    (CMP_W'(held_mid) >= CMP_W'(cfg.long_press_ticks));
      repeat_fire = !debounced_in && !fell && !long_fire && long_mid &&
                    (CMP_W'(since_mid) >= CMP_W'(cfg.repeat_ticks));

      held_count_in   = held_mid;
      long_active_in  = long_mid || long_fire;
      since_repeat_in = (long_fire || repeat_fire) ? '0 : since_mid;

      event_code = blpr_pkg::EV_NONE;
      if (fell) begin
         event_code = blpr_pkg::EV_PRESS;
      end else if (long_fire) begin
         event_code = blpr_pkg::EV_LONG;
      end else if (repeat_fire) begin
         event_code = blpr_pkg::EV_REPEAT;
      end else if (rose) begin
         event_code = long_mid ? blpr_pkg::EV_HOLD_END : blpr_pkg::EV_CLICK;
      end

      word.event_code = event_code;
      word.pressed    = !debounced_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff     <= 1'b1;
         stable_count_ff <= '0;
         debounced_ff    <= 1'b1;
         long_active_ff  <= 1'b0;
         held_count_ff   <= '0;
         since_repeat_ff <= '0;
      end else if (step) begin
         last_raw_ff     <= last_raw_in;
         stable_count_ff <= stable_count_in;
         debounced_ff    <= debounced_in;
         long_active_ff  <= long_active_in;
         held_count_ff   <= held_count_in;
         since_repeat_ff <= since_repeat_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/button_long_press_repeat_core.sv
// Button debounce with long-press detection and auto-repeat. Each input word is
// one millisecond tick carrying the raw active-low pin level in bit 0, and each
// accepted word yields exactly one result word with an event code (none, press,
// long press, repeat, quick-click release, hold release) and the debounced
// pressed level for the LED. A word is accepted every cycle unless the skid entry
// is full; its result is registered into a two-entry output buffer, which keeps the
// input side open while one result waits. Hold timers are TIMER_WIDTH bits wide and saturate.
// Thresholds are set through the APB-style port: debounce ticks at 0x0, long
// press ticks at 0x4, repeat ticks at 0x8; write them only while idle.
`default_nettype none

`include "button_long_press_repeat_core_macros.svh"

module button_long_press_repeat_core #(
   parameter int TIMER_WIDTH = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,

   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [7:0]                      req_tdata,   // [0] raw_level

   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [7:0]                           rsp_tdata,   // [2:0] event_code, [3] pressed

   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [blpr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);

   blpr_pkg::cfg_type       cfg_ff, cfg_in;
   blpr_pkg::reg_index_type csr_index;
   logic                    csr_write;

   blpr_pkg::rsp_word_type  core_word;
   blpr_pkg::rsp_word_type  head_ff, head_in;
   blpr_pkg::rsp_word_type  skid_ff, skid_in;
   logic                    head_valid_ff, head_valid_in;
   logic                    skid_valid_ff, skid_valid_in;
   logic                    req_accept;
   logic                    rsp_pop;

   assign csr_pready = 1'b1;
   assign csr_index  = blpr_pkg::reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            blpr_pkg::REG_DEBOUNCE: begin
               cfg_in.debounce_ticks = csr_pwdata[blpr_pkg::CFG_DEBOUNCE_W-1:0];
            end
            blpr_pkg::REG_LONG_PRESS: begin
               cfg_in.long_press_ticks = csr_pwdata[blpr_pkg::CFG_TICKS_W-1:0];
            end
            blpr_pkg::REG_REPEAT: begin
               cfg_in.repeat_ticks = csr_pwdata[blpr_pkg::CFG_TICKS_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         blpr_pkg::REG_DEBOUNCE:   csr_prdata = 32'(cfg_ff.debounce_ticks);
         blpr_pkg::REG_LONG_PRESS: csr_prdata = 32'(cfg_ff.long_press_ticks);
         blpr_pkg::REG_REPEAT:     csr_prdata = 32'(cfg_ff.repeat_ticks);
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks   <= blpr_pkg::DEBOUNCE_RESET;
         cfg_ff.long_press_ticks <= blpr_pkg::LONG_PRESS_RESET;
         cfg_ff.repeat_ticks     <= blpr_pkg::REPEAT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_pop    = head_valid_ff && rsp_tready;

   blpr_core #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (req_accept),
      .raw_level (req_tdata[0]),
      .cfg       (cfg_ff),
      .word      (core_word)
   );

   always_comb begin
      head_in       = head_ff;
      skid_in       = skid_ff;
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_pop) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_accept) begin
         if (head_valid_ff && !rsp_pop) begin
            skid_in       = core_word;
            skid_valid_in = 1'b1;
         end else begin
            head_in       = core_word;
            head_valid_in = 1'b1;
         end
      end else if (rsp_pop) begin
         head_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = head_valid_ff;
   assign rsp_tdata  = {4'b0000, head_ff.pressed, head_ff.event_code};

   `BLPR_ASSERT_NOW(a_skid_needs_head, clock, reset, skid_valid_ff, head_valid_ff)
   `BLPR_ASSERT_NEXT(a_fill_skid, clock, reset,
      req_accept && head_valid_ff && !rsp_pop, skid_valid_ff)
   `BLPR_ASSERT_NEXT(a_fill_head, clock, reset, req_accept && !head_valid_ff, head_valid_ff)
   `BLPR_ASSERT_NOW(a_held_events_pressed, clock, reset,
      head_valid_ff && (head_ff.event_code == blpr_pkg::EV_PRESS ||
      head_ff.event_code == blpr_pkg::EV_LONG || head_ff.event_code == blpr_pkg::EV_REPEAT),
      head_ff.pressed)
   `BLPR_ASSERT_NOW(a_release_events_released, clock, reset,
      head_valid_ff && (head_ff.event_code == blpr_pkg::EV_CLICK ||
      head_ff.event_code == blpr_pkg::EV_HOLD_END), !head_ff.pressed)

endmodule

`default_nettype wire
